// ===== src/stfa_pkg.sv =====
// Shared types and constants for the segment table frame allocator.
// No dependencies; every other file but stfa_ram refers to it by scoped names.
package stfa_pkg;

  localparam int MAX_SEGMENTS_DEF = 64;

  localparam int OP_W      = 2;
  localparam int ST_W      = 2;
  localparam int CODE_W    = 32;
  localparam int ADDR_W    = 64;
  localparam int PAGES_W   = 52;
  localparam int FRAME_SH  = 12;
  localparam int PFN_W     = ADDR_W - FRAME_SH;
  localparam int ENTRY_W   = PAGES_W + PFN_W;
  localparam int CFG_IDX_W = 1;

  localparam int S_TDATA_W = 152;
  localparam int M_TDATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_USABLE_CODE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RECLAIM_CODE = 1'b1;

  localparam logic [CODE_W-1:0] USABLE_CODE_RST = 32'd7;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_ALLOC = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK   = 2'd0,
    ST_NONE = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_READ,
    S_RESP
  } state_e;

  typedef struct packed {
    logic accept;
    logic scan;
    logic update;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    op_e  in_op;
    logic found;
    logic out_free;
  } ctrl_sts_t;

endpackage

// ===== src/stfa_ram.sv =====
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module stfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/stfa_ctrl.sv =====
// Sequencer for the frame allocator: one op at a time, then the result beat.
// Depends on stfa_pkg.
module stfa_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  stfa_pkg::ctrl_sts_t  sts_i,
  output stfa_pkg::ctrl_cmd_t  cmd_o
);

  stfa_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= stfa_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      stfa_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d = (sts_i.in_op == stfa_pkg::OP_ALLOC) ? stfa_pkg::S_SCAN
                                                        : stfa_pkg::S_RESP;
        end
      end
      stfa_pkg::S_SCAN: begin
        cmd_o.scan = 1'b1;
        state_d = sts_i.found ? stfa_pkg::S_READ : stfa_pkg::S_RESP;
      end
      stfa_pkg::S_READ: begin
        cmd_o.update = 1'b1;
        state_d = stfa_pkg::S_RESP;
      end
      stfa_pkg::S_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d = stfa_pkg::S_IDLE;
        end
      end
      default: state_d = stfa_pkg::S_IDLE;
    endcase
  end

endmodule

// ===== src/stfa_dp.sv =====
// Datapath: type code register, segment RAM, availability mask with a
// two-level registered first-set search, entry count and the output register.
// Depends on stfa_pkg and stfa_ram.
module stfa_dp #(
  parameter int MAX_SEGMENTS = stfa_pkg::MAX_SEGMENTS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  stfa_pkg::ctrl_cmd_t                cmd_i,
  output stfa_pkg::ctrl_sts_t                sts_o,
  input  logic [stfa_pkg::OP_W-1:0]          in_op_i,
  input  logic [stfa_pkg::S_TDATA_W-1:0]     in_data_i,
  input  logic                               cfg_we_i,
  input  logic [stfa_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [stfa_pkg::CODE_W-1:0]        cfg_wdata_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [stfa_pkg::M_TDATA_W-1:0]     out_data_o,
  output logic [stfa_pkg::ST_W-1:0]          out_status_o
);

  localparam int IDX_W  = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CNT_W  = $clog2(MAX_SEGMENTS + 1);
  localparam int GRP_W  = (MAX_SEGMENTS < 32) ? MAX_SEGMENTS : 32;
  localparam int NG     = (MAX_SEGMENTS + GRP_W - 1) / GRP_W;
  localparam int LOW_W  = (GRP_W > 1) ? $clog2(GRP_W) : 1;
  localparam int GSEL_W = (NG > 1) ? $clog2(NG) : 1;
  localparam int PFN_W  = stfa_pkg::PFN_W;
  localparam int PG_W   = stfa_pkg::PAGES_W;

  stfa_pkg::op_e in_op;
  assign in_op = stfa_pkg::op_e'(in_op_i);

  logic [stfa_pkg::CODE_W-1:0]  mem_type;
  logic [stfa_pkg::ADDR_W-1:0]  phys_start;
  logic [PG_W-1:0]              num_pages;
  assign mem_type   = in_data_i[31:0];
  assign phys_start = in_data_i[95:32];
  assign num_pages  = in_data_i[147:96];

  // Only the usable code decides anything: reclaimable and reserved
  // segments are never handed out, so the other code is not kept.
  logic [stfa_pkg::CODE_W-1:0] usable_code_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      usable_code_q <= stfa_pkg::USABLE_CODE_RST;
    end else if (cfg_we_i && cfg_idx_i == stfa_pkg::CFG_USABLE_CODE) begin
      usable_code_q <= cfg_wdata_i;
    end
  end

  // Entry count and availability mask (usable and still holding pages).
  logic [CNT_W-1:0]        count_q;
  logic [MAX_SEGMENTS-1:0] avail_q;
  logic [IDX_W-1:0]        idx_q;
  logic                    full;
  logic [IDX_W-1:0]        count_idx;
  logic                    add_we;
  logic                    add_avail;
  logic [PFN_W-1:0]        add_pfn;

  assign full      = (count_q == CNT_W'(MAX_SEGMENTS));
  assign count_idx = IDX_W'(count_q);
  assign add_we    = cmd_i.accept && (in_op == stfa_pkg::OP_ADD) && !full;
  assign add_avail = (mem_type == usable_code_q) && (num_pages != '0);
  // round up to the next frame boundary, wrapping at the top of memory
  assign add_pfn   = phys_start[stfa_pkg::ADDR_W-1:stfa_pkg::FRAME_SH]
                   + PFN_W'(|phys_start[stfa_pkg::FRAME_SH-1:0]);

  // RAM entry: {pages, frame number}
  logic                          ram_we;
  logic [IDX_W-1:0]              ram_waddr;
  logic [stfa_pkg::ENTRY_W-1:0]  ram_wdata;
  logic [stfa_pkg::ENTRY_W-1:0]  ram_rdata;
  logic [IDX_W-1:0]              scan_idx;
  logic [PFN_W-1:0]              rd_pfn;
  logic [PG_W-1:0]               rd_pages;
  logic [PG_W-1:0]               pages_dec;

  assign rd_pfn    = ram_rdata[PFN_W-1:0];
  assign rd_pages  = ram_rdata[stfa_pkg::ENTRY_W-1:PFN_W];
  assign pages_dec = rd_pages - PG_W'(1);

  assign ram_we    = add_we || cmd_i.update;
  assign ram_waddr = cmd_i.update ? idx_q : count_idx;
  assign ram_wdata = cmd_i.update ? {pages_dec, rd_pfn + PFN_W'(1)}
                                  : {num_pages, add_pfn};

  stfa_ram #(
    .WIDTH (stfa_pkg::ENTRY_W),
    .DEPTH (MAX_SEGMENTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.scan),
    .raddr_i (scan_idx),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      avail_q <= '0;
    end else if (cmd_i.accept && in_op == stfa_pkg::OP_CLEAR) begin
      count_q <= '0;
      avail_q <= '0;
    end else if (add_we) begin
      count_q            <= count_q + CNT_W'(1);
      avail_q[count_idx] <= add_avail;
    end else if (cmd_i.update) begin
      avail_q[idx_q] <= (pages_dec != '0);
    end
  end

  // First level of the search: per group any-set and lowest set bit,
  // registered every cycle. The mask never changes in the cycle before a scan.
  logic [NG*GRP_W-1:0] avail_pad;
  logic [NG-1:0]       grp_any_d, grp_any_q;
  logic [LOW_W-1:0]    grp_low_d [NG];
  logic [LOW_W-1:0]    grp_low_q [NG];

  always_comb begin
    avail_pad = '0;
    avail_pad[MAX_SEGMENTS-1:0] = avail_q;
    for (int g = 0; g < NG; g++) begin
      grp_any_d[g] = |avail_pad[g*GRP_W +: GRP_W];
      grp_low_d[g] = '0;
      for (int b = GRP_W - 1; b >= 0; b--) begin
        if (avail_pad[g*GRP_W + b]) begin
          grp_low_d[g] = LOW_W'(b);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grp_any_q <= '0;
      for (int g = 0; g < NG; g++) begin
        grp_low_q[g] <= '0;
      end
    end else begin
      grp_any_q <= grp_any_d;
      for (int g = 0; g < NG; g++) begin
        grp_low_q[g] <= grp_low_d[g];
      end
    end
  end

  // Second level: first group with a set bit.
  logic [GSEL_W-1:0] gsel;
  logic [31:0]       scan_sum;

  always_comb begin
    gsel = '0;
    for (int g = NG - 1; g >= 0; g--) begin
      if (grp_any_q[g]) begin
        gsel = GSEL_W'(g);
      end
    end
  end

  assign scan_sum = 32'(gsel) * 32'(GRP_W) + 32'(grp_low_q[gsel]);
  assign scan_idx = scan_sum[IDX_W-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan) begin
      idx_q <= scan_idx;
    end
  end

  // Pending result
  logic [stfa_pkg::M_TDATA_W-1:0] res_frame_q;
  stfa_pkg::status_e              res_status_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      res_frame_q  <= '0;
      res_status_q <= (in_op == stfa_pkg::OP_ADD && full) ? stfa_pkg::ST_FULL
                                                           : stfa_pkg::ST_OK;
    end else if (cmd_i.scan) begin
      if (!(|grp_any_q)) begin
        res_status_q <= stfa_pkg::ST_NONE;
      end
    end else if (cmd_i.update) begin
      res_frame_q <= {rd_pfn, {stfa_pkg::FRAME_SH{1'b0}}};
    end
  end

  // Output register
  logic                            out_valid_q;
  logic [stfa_pkg::M_TDATA_W-1:0]  out_data_q;
  logic [stfa_pkg::ST_W-1:0]       out_status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_data_q   <= res_frame_q;
      out_status_q <= res_status_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_data_o   = out_data_q;
  assign out_status_o = out_status_q;

  assign sts_o.in_op    = in_op;
  assign sts_o.found    = |grp_any_q;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

endmodule

// ===== src/segment_table_frame_allocator_core.sv =====
// Segment table frame allocator, top level.
// Usage:
//   Input stream (s_axis_*): one beat per op; tuser carries the opcode
//   (clear, add descriptor, allocate frame, no-op), tdata the descriptor.
//   Output stream (m_axis_*): exactly one result beat per input beat, in
//   order; tdata is the frame address (zero unless an allocation succeeded),
//   tuser the status (ok, no usable segment, table full).
//   Config port: cfg_we_i writes register cfg_idx_i at the clock edge.
//   Index 0 is the usable type code; index 1 (reclaimable code) is accepted
//   and has no effect on results.
// Timing: one op in flight. Clear, add and no-op go from the accept
//   straight to the result load; an allocate first scans the registered
//   group search and reads the RAM, then writes the entry back, or goes
//   straight to the result when nothing usable is left. The next beat is
//   accepted the cycle after the result is loaded, set by the one-op sequencer.
// Reset: table empty, usable code 7, output empty. No clearing pass; the
//   RAM holds only entries below the fill count.
// Stall: a result waits in the output register; the block finishes the
//   next op and holds it until the output register frees up.
// Depends on stfa_pkg, stfa_ctrl, stfa_dp, stfa_ram.
module segment_table_frame_allocator_core #(
  parameter int MAX_SEGMENTS = stfa_pkg::MAX_SEGMENTS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [31:0] mem_type, [95:32] phys_start, [147:96] num_pages, [151:148] zero
  input  logic [stfa_pkg::S_TDATA_W-1:0]    s_axis_tdata,
  // [1:0] opcode
  input  logic [stfa_pkg::OP_W-1:0]         s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [63:0] frame_addr
  output logic [stfa_pkg::M_TDATA_W-1:0]    m_axis_tdata,
  // [1:0] status
  output logic [stfa_pkg::ST_W-1:0]         m_axis_tuser,
  input  logic                              cfg_we_i,
  input  logic [stfa_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [stfa_pkg::CODE_W-1:0]       cfg_wdata_i
);

  stfa_pkg::ctrl_cmd_t cmd;
  stfa_pkg::ctrl_sts_t sts;

  stfa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  stfa_dp #(
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .in_op_i      (s_axis_tuser),
    .in_data_i    (s_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_o   (m_axis_tdata),
    .out_status_o (m_axis_tuser)
  );

endmodule

// ===== src/stfa_checker.sv =====
// Port-level checks for the frame allocator, bound to the top level.
// Depends on stfa_pkg and segment_table_frame_allocator_core.
module stfa_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  input  logic                              s_axis_tready,
  input  logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  input  logic [stfa_pkg::M_TDATA_W-1:0]    m_axis_tdata,
  input  logic [stfa_pkg::ST_W-1:0]         m_axis_tuser
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result beat changed under stall");

  // only a successful allocation carries an address
  a_zero_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != stfa_pkg::ST_OK |-> m_axis_tdata == '0)
    else $error("failed op returned a nonzero address");

  // one op in flight: input closes right after an accept
  a_one_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while an op is in flight");

  // a new result follows a cycle with the input closed
  a_rose_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared without an op in flight");

endmodule

bind segment_table_frame_allocator_core stfa_checker u_stfa_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
